/* design/itrd_pkg.sv */
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and helpers of the integer to radix digits unit.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_RADIX_DEF  = 16;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] DEC_RADIX = 5'd10;
    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef struct packed {
        logic clear;
        logic shift;
        logic feed_valid;
        logic feed_bit;
    } chain_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

/* design/itrd_digit_cell.sv */
// ----------------------------------------------------------------------------
// itrd_digit_cell
// One digit of the systolic doubler: doubles its digit modulo the base and
// adds the carry from the cell below, shifts digits toward the top, or clears.
// ----------------------------------------------------------------------------
module itrd_digit_cell
    import itrd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  chain_ctrl_t        ctrl,
    input  logic [RADIX_W-1:0] base,
    input  logic               carry_in,
    input  logic               valid_in,
    input  logic [DIGIT_W-1:0] shift_in,
    output logic [DIGIT_W-1:0] digit,
    output logic               carry_out,
    output logic               valid_out
);

    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               carry_reg, carry_next;
    logic               valid_reg, valid_next;
    logic [RADIX_W-1:0] sum;
    logic               wrap;

    assign sum  = RADIX_W'({digit_reg, carry_in});
    assign wrap = (sum >= base);

    always_comb begin
        digit_next = digit_reg;
        carry_next = carry_reg;
        valid_next = valid_in;
        if (ctrl.clear) begin
            digit_next = '0;
            carry_next = 1'b0;
            valid_next = 1'b0;
        end else if (ctrl.shift) begin
            digit_next = shift_in;
        end else if (valid_in) begin
            digit_next = wrap ? DIGIT_W'(sum - base) : DIGIT_W'(sum);
            carry_next = wrap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        digit_reg <= digit_next;
        carry_reg <= carry_next;
    end

    assign digit     = digit_reg;
    assign carry_out = carry_reg;
    assign valid_out = valid_reg;

endmodule

/* design/itrd_digit_chain.sv */
// ----------------------------------------------------------------------------
// itrd_digit_chain
// Row of digit cells, least significant first; magnitude bits enter at the
// bottom one per cycle and carries ripple up one cell per cycle.
// ----------------------------------------------------------------------------
module itrd_digit_chain
    import itrd_pkg::*;
#(
    parameter int NUM_DIGITS = VALUE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  chain_ctrl_t        ctrl,
    input  logic [RADIX_W-1:0] base,
    output logic [DIGIT_W-1:0] top_digit
);

    logic [DIGIT_W-1:0] digit_w [NUM_DIGITS];
    logic               carry_w [NUM_DIGITS];
    logic               valid_w [NUM_DIGITS];

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        if (i == 0) begin : g_bottom
            itrd_digit_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .base      (base),
                .carry_in  (ctrl.feed_bit),
                .valid_in  (ctrl.feed_valid),
                .shift_in  ('0),
                .digit     (digit_w[i]),
                .carry_out (carry_w[i]),
                .valid_out (valid_w[i])
            );
        end else begin : g_upper
            itrd_digit_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .base      (base),
                .carry_in  (carry_w[i-1]),
                .valid_in  (valid_w[i-1]),
                .shift_in  (digit_w[i-1]),
                .digit     (digit_w[i]),
                .carry_out (carry_w[i]),
                .valid_out (valid_w[i])
            );
        end
    end

    assign top_digit = digit_w[NUM_DIGITS-1];

endmodule

/* design/integer_to_radix_digits_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts a signed integer to upper-case ASCII digits in base 2 to 16,
// most significant first, with a minus sign in base 10.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  s_value, s_radix
//  m_        out        m_valid / m_ready  m_character, m_last
//
//  Conversion: the systolic doubling chain takes one magnitude bit per cycle.
//  Emit: each of the VALUE_BITS digit positions is sent or, while a leading
//  zero, dropped one per cycle; the last is always sent, after the sign if due.
//  Reset clears control state; the digit chain is cleared on each transfer in.
//  A stall on m_ready holds sign and digit output; s_ready is high only when idle.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit
    import itrd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_RADIX  = MAX_RADIX_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    input  logic        [RADIX_W-1:0]    s_radix,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic        [CHAR_W-1:0]     m_character,
    output logic                         m_last
);

    localparam int NUM_DIGITS = VALUE_BITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + NUM_DIGITS);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);
    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_BITS + NUM_DIGITS - 2);
    localparam logic [CNT_W-1:0] FEED_END  = CNT_W'(VALUE_BITS);
    localparam logic [REM_W-1:0] REM_FULL  = REM_W'(NUM_DIGITS);
    localparam logic [REM_W-1:0] REM_ONE   = REM_W'(1);
    localparam logic [RADIX_W-1:0] RADIX_CAP = RADIX_W'(MAX_RADIX);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic [RADIX_W-1:0]     base_reg, base_next;
    logic                   sign_pending_reg, sign_pending_next;
    logic                   lead_seen_reg, lead_seen_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]      m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;

    logic [VALUE_BITS-1:0]  in_bits;
    logic                   in_neg;
    logic [VALUE_BITS-1:0]  in_mag;
    logic [RADIX_W-1:0]     radix_dec;
    logic [RADIX_W-1:0]     radix_eff;
    logic                   in_xfer;
    logic                   out_free;
    logic                   in_emit;
    logic                   emit_sign;
    logic                   skip_zero;
    logic                   emit_digit;
    logic [DIGIT_W-1:0]     top_digit;
    chain_ctrl_t            chain_ctrl;

    assign in_bits   = s_value;
    assign in_neg    = in_bits[VALUE_BITS-1];
    assign in_mag    = in_neg ? (~in_bits + VALUE_BITS'(1)) : in_bits;
    assign radix_dec = (s_radix < MIN_RADIX) ? DEC_RADIX : s_radix;
    assign radix_eff = (radix_dec > RADIX_CAP) ? RADIX_CAP : radix_dec;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_emit  = (state_reg == ST_EMIT);

    assign emit_sign  = in_emit && sign_pending_reg && out_free;
    assign skip_zero  = in_emit && !sign_pending_reg && !lead_seen_reg
                        && (top_digit == '0) && (rem_reg > REM_ONE);
    assign emit_digit = in_emit && !sign_pending_reg && !skip_zero && out_free;

    assign chain_ctrl.clear      = in_xfer;
    assign chain_ctrl.shift      = skip_zero || emit_digit;
    assign chain_ctrl.feed_valid = (state_reg == ST_CONV) && (cnt_reg < FEED_END);
    assign chain_ctrl.feed_bit   = mag_reg[VALUE_BITS-1];

    itrd_digit_chain #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (chain_ctrl),
        .base      (base_reg),
        .top_digit (top_digit)
    );

    always_comb begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        mag_next          = mag_reg;
        base_next         = base_reg;
        sign_pending_next = sign_pending_reg;
        lead_seen_next    = lead_seen_reg;
        rem_next          = rem_reg;
        m_valid_next      = m_valid_reg;
        m_char_next       = m_char_reg;
        m_last_next       = m_last_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next        = ST_CONV;
                    cnt_next          = '0;
                    mag_next          = in_mag;
                    base_next         = radix_eff;
                    sign_pending_next = in_neg && (radix_eff == DEC_RADIX);
                    lead_seen_next    = 1'b0;
                    rem_next          = REM_FULL;
                end
            end
            ST_CONV: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (chain_ctrl.feed_valid) begin
                    mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                end
                if (cnt_reg == CONV_LAST) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_sign) begin
                    sign_pending_next = 1'b0;
                    m_valid_next      = 1'b1;
                    m_char_next       = CHAR_MINUS;
                    m_last_next       = 1'b0;
                end else if (skip_zero) begin
                    rem_next = rem_reg - REM_ONE;
                end else if (emit_digit) begin
                    rem_next       = rem_reg - REM_ONE;
                    lead_seen_next = 1'b1;
                    m_valid_next   = 1'b1;
                    m_char_next    = digit_char(top_digit);
                    m_last_next    = (rem_reg == REM_ONE);
                    if (rem_reg == REM_ONE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            sign_pending_reg <= 1'b0;
            lead_seen_reg    <= 1'b0;
            rem_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            sign_pending_reg <= sign_pending_next;
            lead_seen_reg    <= lead_seen_next;
            rem_reg          <= rem_next;
            m_valid_reg      <= m_valid_next;
        end
        mag_reg    <= mag_next;
        base_reg   <= base_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last      = m_last_reg;

`ifndef SYNTHESIS
    a_emit_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (rem_reg != '0))
        else $error("emit phase with no digit positions left");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_digit && (rem_reg == REM_ONE)) |=> (state_reg == ST_IDLE))
        else $error("final digit did not return to idle");

    a_accept_starts_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == ST_CONV) && (cnt_reg == '0))
        else $error("transfer in did not start conversion");

    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_char_reg == CHAR_MINUS)) |-> !m_last_reg)
        else $error("minus sign flagged as final character");
`endif

endmodule
